// File: rtl/rrt_pkg.sv
// Shared types and constants for the repeating ramp timeline block.
// Holds the transaction payload structs, configuration record and register codes.
// No dependencies.
package rrt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS = 16;
    localparam int NORM_W = FRAC_BITS + 1;
    localparam int FIELD_W = 32;
    localparam int ELAPSED_W = 48;
    localparam int COUNT_W = 16;
    localparam int LIMIT_W = 17;
    localparam int STYLE_W = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [NORM_W-1:0] NORM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [CFG_INDEX_W-1:0] REG_DURATION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STYLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_DIR = 3'd4;

    localparam logic [STYLE_W-1:0] STYLE_RESTART = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_PINGPONG = 2'd2;

    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] delta_ticks;
    } in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] position_ticks;
        logic [NORM_W-1:0]  normalized_pos;
        logic               end_event;
        logic               repeated;
        logic               moving_backward;
        logic [COUNT_W-1:0] repeat_count_done;
    } out_t;

    typedef struct packed {
        logic [FIELD_W-1:0] duration_ticks;
        logic [STYLE_W-1:0] wrap_mode;
        logic [LIMIT_W-1:0] repeat_limit;
        logic [FIELD_W-1:0] repeat_span_ticks;
        logic               start_direction;
    } cfg_t;

endpackage

// File: rtl/rrt_divider.sv
// Radix-2 serial divider that retires one quotient digit per cycle.
// Computes floor(num * 2^FRAC_BITS / den) for num <= den; a zero divisor gives zero.
// Depends on rrt_pkg.
module rrt_divider
    import rrt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] num,
    input  logic [TIME_BITS-1:0] den,
    output logic                 done,
    output logic [NORM_W-1:0]    quo
);

    localparam int TW = TIME_BITS;
    localparam int CW = $clog2(NORM_W + 1);

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [TW:0]       cur_reg;
    logic [TW:0]       cur_next;
    logic [NORM_W-1:0] quo_reg;
    logic [NORM_W-1:0] quo_next;
    logic              done_reg;
    logic              done_next;
    logic              ge_w;
    logic [TW:0]       rem_w;

    always_comb
    begin
        ge_w = cur_reg >= {1'b0, den};
        rem_w = ge_w ? (cur_reg - {1'b0, den}) : cur_reg;
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        quo_next = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = '0;
            cur_next = {1'b0, num};
            if (den == '0)
            begin
                cnt_next = '0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = CW'(NORM_W);
            end
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[NORM_W-2:0], ge_w};
            cur_next = {rem_w[TW-1:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule

// File: rtl/rrt_step.sv
// Timeline sequencer: holds position, direction and repeat state and applies one item.
// Steps through clamp, move, forward add, end test and optional repeat, then runs the serial divider.
// Depends on rrt_pkg and rrt_divider.
module rrt_step
    import rrt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic start,
    input  in_t  item,
    output logic idle,
    output logic res_valid,
    input  logic res_take,
    output out_t res
);

    localparam int TW = TIME_BITS;
    localparam int W = (TW > FIELD_W) ? TW : FIELD_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLAMP = 4'd1;
    localparam logic [3:0] ST_MOVE = 4'd2;
    localparam logic [3:0] ST_FWD = 4'd3;
    localparam logic [3:0] ST_END = 4'd4;
    localparam logic [3:0] ST_REP = 4'd5;
    localparam logic [3:0] ST_DIV = 4'd6;
    localparam logic [3:0] ST_WAIT = 4'd7;
    localparam logic [3:0] ST_OUT = 4'd8;

    logic [3:0]           state_reg;
    logic [3:0]           state_next;
    logic [TW-1:0]        pos_reg;
    logic [TW-1:0]        pos_next;
    logic                 dir_reg;
    logic                 dir_next;
    logic [COUNT_W-1:0]   reps_reg;
    logic [COUNT_W-1:0]   reps_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic                 end_reg;
    logic                 end_next;
    logic                 rep_reg;
    logic                 rep_next;
    logic [FIELD_W-1:0]   delta_reg;
    logic [FIELD_W-1:0]   delta_next;
    logic [TW-1:0]        p_reg;
    logic [TW-1:0]        p_next;
    logic [TW-1:0]        room_reg;
    logic [TW-1:0]        room_next;

    logic [TW-1:0]        dur_w;
    logic [W:0]           diff_w;
    logic [W-1:0]         sum_w;
    logic                 room_gt_w;
    logic                 end_w;
    logic                 style_ok_w;
    logic                 may_w;
    logic                 dir_new_w;
    logic [ELAPSED_W:0]   elapsed_sum_w;
    logic                 div_done_w;
    logic [NORM_W-1:0]    div_quo_w;

    assign dur_w = TW'(cfg.duration_ticks);
    assign diff_w = {1'b0, W'(p_reg)} - {1'b0, W'(delta_reg)};
    assign sum_w = W'(p_reg) + W'(delta_reg);
    assign room_gt_w = W'(room_reg) > W'(delta_reg);
    assign end_w = (pos_reg == '0) || (pos_reg >= dur_w);
    assign style_ok_w = (cfg.wrap_mode == STYLE_RESTART)
                        || (cfg.wrap_mode == STYLE_PINGPONG);
    assign may_w = (cfg.repeat_limit == '1)
                   || (!cfg.repeat_limit[LIMIT_W-1] && (cfg.repeat_limit != '0)
                       && ({1'b0, reps_reg} < cfg.repeat_limit))
                   || ((cfg.repeat_span_ticks != '0)
                       && (elapsed_reg < ELAPSED_W'(cfg.repeat_span_ticks)));
    assign dir_new_w = (cfg.wrap_mode == STYLE_PINGPONG) ? !dir_reg : dir_reg;
    assign elapsed_sum_w = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(dur_w);

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        dir_next = dir_reg;
        reps_next = reps_reg;
        elapsed_next = elapsed_reg;
        end_next = end_reg;
        rep_next = rep_reg;
        delta_next = delta_reg;
        p_next = p_reg;
        room_next = room_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    delta_next = item.delta_ticks;
                    end_next = 1'b0;
                    rep_next = 1'b0;
                    if (item.func == FUNC_RESTART)
                    begin
                        dir_next = cfg.start_direction;
                        pos_next = cfg.start_direction ? dur_w : '0;
                        reps_next = '0;
                        elapsed_next = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_CLAMP;
                    end
                end
            end
            ST_CLAMP:
            begin
                p_next = (pos_reg > dur_w) ? dur_w : pos_reg;
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (dir_reg)
                begin
                    pos_next = diff_w[W] ? '0 : TW'(diff_w[W-1:0]);
                    state_next = ST_END;
                end
                else
                begin
                    room_next = dur_w - p_reg;
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                pos_next = room_gt_w ? TW'(sum_w) : dur_w;
                state_next = ST_END;
            end
            ST_END:
            begin
                end_next = end_w;
                rep_next = end_w && style_ok_w && may_w;
                state_next = (end_w && style_ok_w && may_w) ? ST_REP : ST_DIV;
            end
            ST_REP:
            begin
                reps_next = (reps_reg != '1) ? (reps_reg + COUNT_W'(1)) : reps_reg;
                elapsed_next = elapsed_sum_w[ELAPSED_W] ? '1
                                                        : elapsed_sum_w[ELAPSED_W-1:0];
                dir_next = dir_new_w;
                pos_next = dir_new_w ? dur_w : '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done_w)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg <= '0;
            dir_reg <= 1'b0;
            reps_reg <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            dir_reg <= dir_next;
            reps_reg <= reps_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg <= end_next;
        rep_reg <= rep_next;
        delta_reg <= delta_next;
        p_reg <= p_next;
        room_reg <= room_next;
    end

    rrt_divider #(
        .TIME_BITS(TIME_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIV),
        .num   (pos_reg),
        .den   (dur_w),
        .done  (div_done_w),
        .quo   (div_quo_w)
    );

    assign idle = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    always_comb
    begin
        res.position_ticks = FIELD_W'(pos_reg);
        res.normalized_pos = div_quo_w;
        res.end_event = end_reg;
        res.repeated = rep_reg;
        res.moving_backward = dir_reg;
        res.repeat_count_done = reps_reg;
    end

endmodule

// File: rtl/repeating_ramp_timeline_core.sv
// Top level of the repeating ramp timeline: configuration registers and output register.
// Instantiates rrt_step, which holds the timeline state and the serial divider.
// Depends on rrt_pkg, rrt_step and rrt_divider.
//
// Each input transaction restarts the timeline or steps it by delta_ticks, and yields exactly
// one result transaction. A step goes through the sequencer states for clamp, move, a forward
// add (only when moving forward), end test and an optional repeat; a restart skips them. The
// normalized position then comes from a start state, FRAC_BITS + 1 = 17 quotient bits from a
// radix-2 divider at one bit per cycle, and a wait state that sees the divider finish. The
// result then moves into the output register once that register is free or being read, and
// out_valid rises. The block works on one transaction at a time; the next one is accepted on
// the cycle after the result has moved into the output register, even if it has not yet been
// taken.
module repeating_ramp_timeline_core
    import rrt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_t                   out_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic out_valid_reg;
    logic out_valid_next;
    out_t out_data_reg;
    out_t out_data_next;

    logic step_idle_w;
    logic res_valid_w;
    logic res_take_w;
    out_t res_w;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DURATION:  cfg_next.duration_ticks = cfg_data[FIELD_W-1:0];
                REG_STYLE:     cfg_next.wrap_mode = cfg_data[STYLE_W-1:0];
                REG_LIMIT:     cfg_next.repeat_limit = cfg_data[LIMIT_W-1:0];
                REG_SPAN:      cfg_next.repeat_span_ticks = cfg_data[FIELD_W-1:0];
                REG_START_DIR: cfg_next.start_direction = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duration_ticks <= FIELD_W'(1);
            cfg_reg.wrap_mode <= '0;
            cfg_reg.repeat_limit <= '0;
            cfg_reg.repeat_span_ticks <= '0;
            cfg_reg.start_direction <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = step_idle_w;
    assign res_take_w = res_valid_w && (!out_valid_reg || out_ready);

    rrt_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (in_valid && step_idle_w),
        .item      (in_data),
        .idle      (step_idle_w),
        .res_valid (res_valid_w),
        .res_take  (res_take_w),
        .res       (res_w)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (res_take_w)
        begin
            out_valid_next = 1'b1;
            out_data_next = res_w;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // Once a transaction is taken, the sequencer is busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again right after a transaction");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.normalized_pos <= NORM_ONE)
        else $error("normalized position above one");

    a_repeat_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.repeated |-> out_data.end_event)
        else $error("repeat reported without an end event");

endmodule
